### hdl/fhnd_pkg.sv
// fhnd_pkg: shared types and constants for the force hit note detector
// no dependencies; used by force_hit_note_detector
`timescale 1ns / 1ps

package fhnd_pkg;

  // full-scale inverted reading
  localparam logic [10:0] FULL_SCALE = 11'd1024;

  // register defaults
  localparam logic [9:0]  FORCE_THR_RST   = 10'd500;
  localparam logic [10:0] OFF_THR_RST     = 11'd200;
  localparam logic [15:0] CAPTURE_WIN_RST = 16'd10;
  localparam logic [7:0]  MIN_TRIG_RST    = 8'd2;
  localparam logic [7:0]  MIN_OFF_RST     = 8'd2;
  localparam logic [15:0] OFF_DELAY_RST   = 16'd10;

  // divider: quotient bits, one per step
  localparam int unsigned DIV_STEPS = 11;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    REG_FORCE_THR   = 3'd0,
    REG_OFF_THR     = 3'd1,
    REG_CAPTURE_WIN = 3'd2,
    REG_MIN_TRIG    = 3'd3,
    REG_MIN_OFF     = 3'd4,
    REG_OFF_DELAY   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NOTE_ON  = 2'd1,
    EV_NOTE_OFF = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } state_e;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

### hdl/force_hit_note_detector.sv
// force_hit_note_detector: top level, sequencer around a shared restoring divider
// depends on fhnd_pkg
`timescale 1ns / 1ps

// Drum-trigger style hit detector. Each input transaction carries one raw
// 10-bit force sample (inverted inside as 1024 - sample) and a millisecond
// time stamp, and produces exactly one output transaction: an event code
// (none, note on, note off), the note-on velocity, and the lamp state.
// A sample whose inverted reading is above the hit threshold is a hit; its
// velocity (r - T) * 1024 / (1024 - T) is found by a restoring divider, one
// quotient bit per cycle. A sample that is not a hit goes through accept and
// evaluate; a hit goes through accept, 11 divide steps and evaluate. One
// transaction is in work at a time; the input is ready
// again once the result is loaded in the output register, and the result
// waits there while the next sample is already being worked on. A stalled
// output holds the block in its evaluate step. Configuration writes
// (cfg_index_i 0..5, higher indexes ignored) are always taken and must be
// made only while the block is idle.
module force_hit_note_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [9:0]  adc_sample_i,
  input  logic [31:0] now_ms_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [10:0] velocity_o,
  output logic        led_on_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [9:0]  force_thr_q;
  logic [10:0] off_thr_q;
  logic [15:0] capture_win_q;
  logic [7:0]  min_trig_q;
  logic [7:0]  min_off_q;
  logic [15:0] off_delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_thr_q   <= fhnd_pkg::FORCE_THR_RST;
      off_thr_q     <= fhnd_pkg::OFF_THR_RST;
      capture_win_q <= fhnd_pkg::CAPTURE_WIN_RST;
      min_trig_q    <= fhnd_pkg::MIN_TRIG_RST;
      min_off_q     <= fhnd_pkg::MIN_OFF_RST;
      off_delay_q   <= fhnd_pkg::OFF_DELAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fhnd_pkg::REG_FORCE_THR:   force_thr_q   <= cfg_data_i[9:0];
        fhnd_pkg::REG_OFF_THR:     off_thr_q     <= cfg_data_i[10:0];
        fhnd_pkg::REG_CAPTURE_WIN: capture_win_q <= cfg_data_i;
        fhnd_pkg::REG_MIN_TRIG:    min_trig_q    <= cfg_data_i[7:0];
        fhnd_pkg::REG_MIN_OFF:     min_off_q     <= cfg_data_i[7:0];
        fhnd_pkg::REG_OFF_DELAY:   off_delay_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  fhnd_pkg::state_e state_q, state_d;
  logic [fhnd_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic in_fire;
  logic div_step;
  logic eval_fire;
  logic out_free;
  logic hit_q;
  logic hit_in;   // arriving sample is a hit

  assign out_free = !out_valid_o || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      fhnd_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = hit_in ? fhnd_pkg::ST_DIV : fhnd_pkg::ST_EVAL;
        end
      end
      fhnd_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == fhnd_pkg::DIV_CNT_W'(fhnd_pkg::DIV_STEPS - 1)) begin
          state_d = fhnd_pkg::ST_EVAL;
        end
      end
      fhnd_pkg::ST_EVAL: begin
        if (out_free) begin
          state_d = fhnd_pkg::ST_IDLE;
        end
      end
      default: state_d = fhnd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_step   = 1'b0;
    eval_fire  = 1'b0;
    unique case (state_q)
      fhnd_pkg::ST_IDLE: in_ready_o = 1'b1;
      fhnd_pkg::ST_DIV:  div_step   = 1'b1;
      fhnd_pkg::ST_EVAL: eval_fire  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fhnd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------
  // capture of the sample
  // ---------------------------------------------------------------
  logic [10:0] r_in;     // inverted reading of the arriving sample
  logic [10:0] r_q;
  logic [31:0] now_q;
  logic [10:0] delta_in; // r - T for a hit

  assign r_in     = fhnd_pkg::FULL_SCALE - {1'b0, adc_sample_i};
  assign delta_in = r_in - {1'b0, force_thr_q};
  assign hit_in   = r_in > {1'b0, force_thr_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_q   <= r_in;
      now_q <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (in_fire) begin
      hit_q <= hit_in;
    end
  end

  // ---------------------------------------------------------------
  // shared restoring divider: (delta << 10) / (1024 - T)
  // quotient never exceeds 1024, so the top 10 numerator bits
  // (delta >> 1) preload the remainder and 11 steps remain
  // ---------------------------------------------------------------
  logic [10:0] rem_q;
  logic [10:0] nlo_q;
  logic [10:0] quo_q;
  logic [10:0] divisor;
  logic [11:0] trial;
  logic        q_bit;

  assign divisor = fhnd_pkg::FULL_SCALE - {1'b0, force_thr_q};
  assign trial   = {rem_q, nlo_q[10]};
  assign q_bit   = trial >= {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rem_q <= {1'b0, delta_in[10:1]};
      nlo_q <= {delta_in[0], 10'b0};
      quo_q <= '0;
    end else if (div_step) begin
      rem_q <= q_bit ? 11'(trial - {1'b0, divisor}) : trial[10:0];
      nlo_q <= {nlo_q[9:0], 1'b0};
      quo_q <= {quo_q[9:0], q_bit};
    end
  end

  // ---------------------------------------------------------------
  // detector state and evaluate step
  // ---------------------------------------------------------------
  logic        note_active_q, note_active_d;
  logic        fh_valid_q, fh_valid_d;
  logic [31:0] fh_time_q, fh_time_d;
  logic [10:0] held_vel_q, held_vel_d;
  logic [7:0]  hit_cnt_q, hit_cnt_d;
  logic [7:0]  rel_cnt_q, rel_cnt_d;
  logic [31:0] start_time_q, start_time_d;
  logic        lamp_q, lamp_d;
  logic [1:0]  ev_d;
  logic [10:0] vel_d;
  logic [10:0] vel_clamped;
  logic [31:0] since_hit;
  logic [31:0] since_start;

  assign vel_clamped = (quo_q > fhnd_pkg::FULL_SCALE) ? fhnd_pkg::FULL_SCALE : quo_q;
  assign since_start = now_q - start_time_q;

  always_comb begin
    note_active_d = note_active_q;
    fh_valid_d    = fh_valid_q;
    fh_time_d     = fh_time_q;
    held_vel_d    = held_vel_q;
    hit_cnt_d     = hit_cnt_q;
    rel_cnt_d     = rel_cnt_q;
    start_time_d  = start_time_q;
    lamp_d        = lamp_q;
    ev_d          = fhnd_pkg::EV_NONE;
    vel_d         = '0;

    // hit sample bookkeeping
    if (hit_q) begin
      hit_cnt_d  = fhnd_pkg::sat_inc(hit_cnt_q);
      if (!fh_valid_q) begin
        fh_valid_d = 1'b1;
        fh_time_d  = now_q;
      end
      held_vel_d = vel_clamped;
      lamp_d     = 1'b1;
    end

    // window measured from the first hit, including one taken just now
    since_hit = now_q - fh_time_d;

    if (!note_active_q && held_vel_d != '0) begin
      // note-on decision once the capture window has run out
      if (since_hit > {16'b0, capture_win_q}) begin
        if (hit_cnt_d < min_trig_q) begin
          note_active_d = 1'b0;
          fh_valid_d    = 1'b0;
          held_vel_d    = '0;
          hit_cnt_d     = '0;
          rel_cnt_d     = '0;
          lamp_d        = 1'b0;
        end else begin
          note_active_d = 1'b1;
          start_time_d  = now_q;
          ev_d          = fhnd_pkg::EV_NOTE_ON;
          vel_d         = held_vel_d;
        end
      end
    end else if (note_active_q) begin
      // release counting while the note sounds
      if (r_q <= off_thr_q) begin
        rel_cnt_d = fhnd_pkg::sat_inc(rel_cnt_q);
        if (rel_cnt_d > min_off_q && since_start > {16'b0, off_delay_q}) begin
          note_active_d = 1'b0;
          fh_valid_d    = 1'b0;
          held_vel_d    = '0;
          hit_cnt_d     = '0;
          rel_cnt_d     = '0;
          lamp_d        = 1'b0;
          ev_d          = fhnd_pkg::EV_NOTE_OFF;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_active_q <= 1'b0;
      fh_valid_q    <= 1'b0;
      fh_time_q     <= '0;
      held_vel_q    <= '0;
      hit_cnt_q     <= '0;
      rel_cnt_q     <= '0;
      start_time_q  <= '0;
      lamp_q        <= 1'b0;
    end else if (eval_fire) begin
      note_active_q <= note_active_d;
      fh_valid_q    <= fh_valid_d;
      fh_time_q     <= fh_time_d;
      held_vel_q    <= held_vel_d;
      hit_cnt_q     <= hit_cnt_d;
      rel_cnt_q     <= rel_cnt_d;
      start_time_q  <= start_time_d;
      lamp_q        <= lamp_d;
    end
  end

  // ---------------------------------------------------------------
  // output register: holds one result transaction
  // ---------------------------------------------------------------
  logic        out_valid_q;
  logic [1:0]  event_q;
  logic [10:0] velocity_q;
  logic        led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      event_q    <= ev_d;
      velocity_q <= vel_d;
      led_q      <= lamp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign velocity_o  = velocity_q;
  assign led_on_o    = led_q;

endmodule
